@@ rtl/dsac_pkg.sv @@
// Shared types and constants for the depth-sorted alpha compositor.
package dsac_pkg;

    localparam int DEPTH_W = 32;
    localparam int CHAN_W  = 8;
    localparam int PROD_W  = 16;
    localparam int SUM_W   = 17;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // One held contribution: depth key and RGBA colour
    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [CHAN_W-1:0]         alpha;
        logic [CHAN_W-1:0]         blue;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         red;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_READ,
        S_INS_CMP,
        S_INS_PLACE,
        S_BL_START,
        S_BL_CH,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

endpackage

@@ rtl/dsac_mem.sv @@
// Contribution store: one write port, one read port with registered read data.
module dsac_mem
    import dsac_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data valid the cycle after re
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dsac_blend.sv @@
// Single-channel over-blend: floor((c*a + dest*(255-a)) / 255).
module dsac_blend
    import dsac_pkg::*;
(
    input  logic [CHAN_W-1:0] chan,
    input  logic [CHAN_W-1:0] alpha,
    input  logic [CHAN_W-1:0] dest,
    output logic [CHAN_W-1:0] result
);

    logic [PROD_W-1:0] prod_src;
    logic [PROD_W-1:0] prod_dst;
    logic [SUM_W-1:0]  sum_p1;
    logic [SUM_W-1:0]  quot_tmp;

    assign prod_src = PROD_W'(chan) * PROD_W'(alpha);
    assign prod_dst = PROD_W'(dest) * PROD_W'(CHAN_MAX - alpha);

    // Divide by 255: q = (x+1 + ((x+1)>>8)) >> 8, exact for x <= 255*255
    assign sum_p1   = SUM_W'(prod_src) + SUM_W'(prod_dst) + SUM_W'(1);
    assign quot_tmp = sum_p1 + (sum_p1 >> CHAN_W);
    assign result   = quot_tmp[2*CHAN_W-1:CHAN_W];

endmodule

@@ rtl/depth_sorted_alpha_composite_top.sv @@
// Top level of the depth-sorted alpha compositor: sequencer, store and blend unit.
// A contribution is accepted while idle, then insertion-sorted into the store, shifting larger
//   entries up; it is placed directly when the store is empty and dropped when the store is full.
// A closing item then runs the blend walk over every held entry (one channel per cycle), then
//   loads the output register, waiting there while the previous result is stalled.
// Throughput: one item in flight, in_ready only while idle; rst_n async clears all control.
module depth_sorted_alpha_composite_top
    import dsac_pkg::*;
#(
    parameter int MAX_CONTRIBS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [DEPTH_W-1:0] depth,
    input  logic [CHAN_W-1:0]         red_in,
    input  logic [CHAN_W-1:0]         green_in,
    input  logic [CHAN_W-1:0]         blue_in,
    input  logic [CHAN_W-1:0]         alpha_in,
    input  logic                      no_contribution,
    input  logic                      last_of_pixel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CHAN_W-1:0]         red_out,
    output logic [CHAN_W-1:0]         green_out,
    output logic [CHAN_W-1:0]         blue_out,
    output logic                      overflowed
);

    localparam int IDX_W = (MAX_CONTRIBS > 1) ? $clog2(MAX_CONTRIBS) : 1;
    localparam int CNT_W = $clog2(MAX_CONTRIBS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CONTRIBS);

    state_t            state_reg, state_next;
    chan_t             ch_reg, ch_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;
    entry_t            new_reg, new_next;
    logic [CHAN_W-1:0] r_reg, r_next;
    logic [CHAN_W-1:0] g_reg, g_next;
    logic [CHAN_W-1:0] b_reg, b_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0] red_out_reg, red_out_next;
    logic [CHAN_W-1:0] green_out_reg, green_out_next;
    logic [CHAN_W-1:0] blue_out_reg, blue_out_next;
    logic              ovf_out_reg, ovf_out_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            mem_rdata;

    logic [CHAN_W-1:0] bl_chan;
    logic [CHAN_W-1:0] bl_dest;
    logic [CHAN_W-1:0] bl_result;

    logic [CNT_W-1:0]  pos_dec;
    logic [CNT_W-1:0]  pos_dec2;
    logic [CNT_W-1:0]  k_inc;
    logic [CNT_W-1:0]  count_inc;
    state_t            after_insert;

    assign pos_dec      = pos_reg - CNT_W'(1);
    assign pos_dec2     = pos_reg - CNT_W'(2);
    assign k_inc        = k_reg + CNT_W'(1);
    assign count_inc    = count_reg + CNT_W'(1);
    assign after_insert = last_reg ? S_BL_START : S_IDLE;

    dsac_mem #(
        .DEPTH (MAX_CONTRIBS),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Channel select for the shared blend unit
    always_comb
    begin
        unique case (ch_reg)
            CH_RED:
            begin
                bl_chan = mem_rdata.red;
                bl_dest = r_reg;
            end
            CH_GREEN:
            begin
                bl_chan = mem_rdata.green;
                bl_dest = g_reg;
            end
            CH_BLUE:
            begin
                bl_chan = mem_rdata.blue;
                bl_dest = b_reg;
            end
            default:
            begin
                bl_chan = mem_rdata.red;
                bl_dest = r_reg;
            end
        endcase
    end

    dsac_blend u_blend (
        .chan   (bl_chan),
        .alpha  (mem_rdata.alpha),
        .dest   (bl_dest),
        .result (bl_result)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= CH_RED;
            count_reg     <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        new_reg       <= new_next;
        r_reg         <= r_next;
        g_reg         <= g_next;
        b_reg         <= b_next;
        red_out_reg   <= red_out_next;
        green_out_reg <= green_out_next;
        blue_out_reg  <= blue_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    // Sequencer: insertion sort into the store, then for a closing item blend walk and output load
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        new_next       = new_reg;
        r_next         = r_reg;
        g_next         = g_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg && !out_ready;
        red_out_next   = red_out_reg;
        green_out_next = green_out_reg;
        blue_out_next  = blue_out_reg;
        ovf_out_next   = ovf_out_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[IDX_W-1:0];
        mem_wdata      = new_reg;
        mem_re         = 1'b0;
        mem_raddr      = pos_dec[IDX_W-1:0];
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    new_next.depth = depth;
                    new_next.alpha = alpha_in;
                    new_next.blue  = blue_in;
                    new_next.green = green_in;
                    new_next.red   = red_in;
                    last_next      = last_of_pixel;
                    pos_next       = count_reg;
                    priority if (no_contribution)
                    begin
                        state_next = S_BL_START;
                    end
                    else if (count_reg == CNT_FULL)
                    begin
                        ovf_next   = 1'b1;
                        state_next = last_of_pixel ? S_BL_START : S_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_INS_PLACE;
                    end
                    else
                    begin
                        state_next = S_INS_READ;
                    end
                end
            end
            S_INS_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = pos_dec[IDX_W-1:0];
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (mem_rdata.depth > new_reg.depth)
                begin
                    // Shift the larger entry up one slot
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[IDX_W-1:0];
                    mem_wdata = mem_rdata;
                    pos_next  = pos_dec;
                    if (pos_reg == CNT_W'(1))
                    begin
                        state_next = S_INS_PLACE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_dec2[IDX_W-1:0];
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[IDX_W-1:0];
                    mem_wdata  = new_reg;
                    count_next = count_inc;
                    state_next = after_insert;
                end
            end
            S_INS_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[IDX_W-1:0];
                mem_wdata  = new_reg;
                count_next = count_inc;
                state_next = after_insert;
            end
            S_BL_START:
            begin
                r_next  = CHAN_MAX;
                g_next  = CHAN_MAX;
                b_next  = CHAN_MAX;
                k_next  = '0;
                ch_next = CH_RED;
                if (count_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    state_next = S_BL_CH;
                end
            end
            S_BL_CH:
            begin
                unique case (ch_reg)
                    CH_RED:
                    begin
                        r_next  = bl_result;
                        ch_next = CH_GREEN;
                    end
                    CH_GREEN:
                    begin
                        g_next  = bl_result;
                        ch_next = CH_BLUE;
                    end
                    CH_BLUE:
                    begin
                        b_next  = bl_result;
                        ch_next = CH_RED;
                        k_next  = k_inc;
                        if (k_inc == count_reg)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = k_inc[IDX_W-1:0];
                        end
                    end
                    default:
                    begin
                        ch_next = CH_RED;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    red_out_next   = r_reg;
                    green_out_next = g_reg;
                    blue_out_next  = b_reg;
                    ovf_out_next   = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = red_out_reg;
    assign green_out  = green_out_reg;
    assign blue_out   = blue_out_reg;
    assign overflowed = ovf_out_reg;

endmodule

@@ rtl/dsac_checker.sv @@
// Port-level checks for the compositor top level, with bind.
module dsac_checker
    import dsac_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              no_contribution,
    input logic              last_of_pixel,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAN_W-1:0] red_out,
    input logic [CHAN_W-1:0] green_out,
    input logic [CHAN_W-1:0] blue_out,
    input logic              overflowed
);

    // A stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(overflowed))
        else $error("result changed while stalled");

    // A closing transaction keeps the block busy for the blend walk
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (no_contribution || last_of_pixel) |=> !in_ready)
        else $error("input ready right after a closing transaction");

    // A non-closing contribution never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !no_contribution && !last_of_pixel |=> !$rose(out_valid))
        else $error("result after a non-closing transaction");

    // No result appears while the block waits for input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> !$rose(out_valid))
        else $error("result appeared while idle");

endmodule

bind depth_sorted_alpha_composite_top dsac_checker u_dsac_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .no_contribution (no_contribution),
    .last_of_pixel   (last_of_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .red_out         (red_out),
    .green_out       (green_out),
    .blue_out        (blue_out),
    .overflowed      (overflowed)
);
